>>> src/wpd_pkg.sv
// types, constants and horner series tables for the waypoint distance block
package wpd_pkg;

   typedef logic signed [19:0] lat_type;
   typedef logic signed [20:0] lon_type;
   typedef logic [22:0]        scale_type;
   typedef logic [29:0]        seg_type;
   typedef logic [47:0]        total_type;
   typedef logic [2:0]         hstep_type;

   localparam scale_type SCALE_RESET = 23'd2036858;
   localparam seg_type   SEG_MAX     = '1;
   localparam total_type TOTAL_MAX   = '1;

   // angles in half arc-seconds, radians and cosine in q30
   localparam logic [30:0] Q30_ONE               = 31'h4000_0000;
   localparam logic [20:0] HALF_TURN_HALF_SEC    = 21'd1296000;
   localparam logic [20:0] QUARTER_TURN_HALF_SEC = 21'd648000;
   localparam logic [21:0] RAD_PER_HALF_SEC_Q40  = 22'd2665291;

   localparam hstep_type HORNER_LAST = 3'd4;

   // divisor of each horner step
   function automatic logic [7:0] horner_div(input hstep_type idx);
      logic [7:0] n;
      unique case (idx)
         3'd0:    n = 8'd132;
         3'd1:    n = 8'd90;
         3'd2:    n = 8'd56;
         3'd3:    n = 8'd30;
         default: n = 8'd12;
      endcase
      return n;
   endfunction

   // floor(2^s / n), s = 32 + floor(log2 n), so the quotient is low by at most one
   function automatic logic [31:0] horner_recip(input hstep_type idx);
      logic [31:0] m;
      unique case (idx)
         3'd0:    m = 32'd4164816771;
         3'd1:    m = 32'd3054198966;
         3'd2:    m = 32'd2454267026;
         3'd3:    m = 32'd2290649224;
         default: m = 32'd2863311530;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] horner_shift(input hstep_type idx);
      logic [5:0] s;
      unique case (idx)
         3'd0:    s = 6'd39;
         3'd1:    s = 6'd38;
         3'd2:    s = 6'd37;
         3'd3:    s = 6'd36;
         default: s = 6'd35;
      endcase
      return s;
   endfunction

endpackage

>>> src/waypoint_path_distance.sv
// waypoint path length: one shared 32x32 multiplier under a sequencer, bit-serial root
// a measured segment runs the horner series and the root; a leg that saturates skips the
// root, and the first waypoint of a path goes straight to its result word
// a new word is taken only in idle, once the last result is loaded; the multiplier steps
// (3 per horner term) and the 31-step root set the pace; a stalled result holds the sequencer
// reset (synchronous, active high) clears the path state and restores the scale register
module waypoint_path_distance #(
   parameter int DIST_FRAC_BITS = 4,
   parameter int COS_FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wpd_pkg::lat_type     req_lat_arcsec,
   input  wpd_pkg::lon_type     req_lon_arcsec,
   input  logic                 req_path_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wpd_pkg::seg_type     rsp_segment_dist,
   output wpd_pkg::total_type   rsp_total_dist,
   output logic                 rsp_segment_valid,
   input  logic                 csr_wr_en,
   input  wpd_pkg::scale_type   csr_wr_data
);
   import wpd_pkg::*;

   localparam int COS_W   = COS_FRAC_BITS + 1;
   localparam int ACC_W   = 18 + COS_W;
   localparam int SUM_W   = 36 + COS_W;
   localparam int DX16_W  = SUM_W - (COS_FRAC_BITS - 8);
   localparam int DXQ_W   = DX16_W + 1 - (16 - DIST_FRAC_BITS);
   localparam logic [31:0] COS_RND = 32'(1) << (29 - COS_FRAC_BITS);
   localparam logic [DX16_W:0] DIST_RND = (DX16_W + 1)'(1) << (15 - DIST_FRAC_BITS);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_PREP = 5'd1;
   localparam logic [4:0] ST_FOLD = 5'd2;
   localparam logic [4:0] ST_XM   = 5'd3;
   localparam logic [4:0] ST_X2M  = 5'd4;
   localparam logic [4:0] ST_X2R  = 5'd5;
   localparam logic [4:0] ST_HM   = 5'd6;
   localparam logic [4:0] ST_HR   = 5'd7;
   localparam logic [4:0] ST_HQ   = 5'd8;
   localparam logic [4:0] ST_HC   = 5'd9;
   localparam logic [4:0] ST_HL   = 5'd10;
   localparam logic [4:0] ST_HU   = 5'd11;
   localparam logic [4:0] ST_COS  = 5'd12;
   localparam logic [4:0] ST_DY   = 5'd13;
   localparam logic [4:0] ST_DV   = 5'd14;
   localparam logic [4:0] ST_DL   = 5'd15;
   localparam logic [4:0] ST_DH   = 5'd16;
   localparam logic [4:0] ST_DS   = 5'd17;
   localparam logic [4:0] ST_DR   = 5'd18;
   localparam logic [4:0] ST_SAT  = 5'd19;
   localparam logic [4:0] ST_SQ2  = 5'd20;
   localparam logic [4:0] ST_SQ3  = 5'd21;
   localparam logic [4:0] ST_ROOT = 5'd22;
   localparam logic [4:0] ST_TOT  = 5'd23;
   localparam logic [4:0] ST_DONE = 5'd24;

   logic [4:0]          state_ff, state_in;
   lat_type             cur_lat_ff, cur_lat_in;
   lon_type             cur_lon_ff, cur_lon_in;
   logic                start_ff, start_in;
   lat_type             prev_lat_ff, prev_lat_in;
   lon_type             prev_lon_ff, prev_lon_in;
   logic                have_prev_ff, have_prev_in;
   scale_type           scale_ff, scale_in;
   logic [20:0]         ang_ff, ang_in;
   logic [19:0]         dlat_ff, dlat_in;
   logic [20:0]         dlon_ff, dlon_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         x2_ff, x2_in;
   logic [30:0]         t_ff, t_in;
   logic [31:0]         p_ff, p_in;
   logic [28:0]         q0_ff, q0_in;
   hstep_type           h_idx_ff, h_idx_in;
   logic [30:0]         c_ff, c_in;
   logic [COS_W-1:0]    cos_ff, cos_in;
   logic [17:0]         vh_ff, vh_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DX16_W-1:0]   dx16_ff, dx16_in;
   logic [DXQ_W-1:0]    dx_ff, dx_in;
   logic [DXQ_W-1:0]    dy_ff, dy_in;
   logic [61:0]         sq_ff, sq_in;
   logic [31:0]         rem_ff, rem_in;
   logic [30:0]         root_ff, root_in;
   logic [4:0]          cnt_ff, cnt_in;
   seg_type             seg_ff, seg_in;
   total_type           total_ff, total_in;
   logic                segv_ff, segv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   seg_type             rsp_seg_ff, rsp_seg_in;
   total_type           rsp_total_ff, rsp_total_in;
   logic                rsp_segv_ff, rsp_segv_in;

   logic [31:0]         mul_a, mul_b;
   logic [20:0]         lat_sum, lat_diff;
   logic [21:0]         lon_diff;
   logic [28:0]         q0_w;
   logic [31:0]         hc_rem;
   logic                hc_corr;
   logic [30:0]         u_w;
   logic [31:0]         cos_sum;
   logic [SUM_W-1:0]    acc_sum;
   logic [DX16_W:0]     rnd_sum;
   logic [33:0]         rem_sh, trial;
   seg_type             seg_w;
   logic [48:0]         total_sum;
   logic                load_rsp;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_dist  = rsp_seg_ff;
   assign rsp_total_dist    = rsp_total_ff;
   assign rsp_segment_valid = rsp_segv_ff;

   // arithmetic feeding the sequencer
   always_comb begin
      lat_sum  = {cur_lat_ff[19], cur_lat_ff} + {prev_lat_ff[19], prev_lat_ff};
      lat_diff = {cur_lat_ff[19], cur_lat_ff} - {prev_lat_ff[19], prev_lat_ff};
      lon_diff = {cur_lon_ff[20], cur_lon_ff} - {prev_lon_ff[20], prev_lon_ff};
      q0_w     = 29'(prod_ff >> horner_shift(h_idx_ff));
      hc_rem   = p_ff - prod_ff[31:0];
      hc_corr  = (hc_rem >= 32'(horner_div(h_idx_ff)));
      u_w      = prod_ff[61:31];
      cos_sum  = 32'(c_ff) + COS_RND;
      acc_sum  = SUM_W'(acc_ff) + (SUM_W'(prod_ff[ACC_W-1:0]) << 18);
      // shared round-half-up to the output fraction
      if (state_ff == ST_DV) begin
         rnd_sum = (DX16_W + 1)'(prod_ff[42:0]) + DIST_RND;
      end else begin
         rnd_sum = (DX16_W + 1)'(dx16_ff) + DIST_RND;
      end
      rem_sh    = {rem_ff, sq_ff[61:60]};
      trial     = {1'b0, root_ff, 2'b01};
      seg_w     = root_ff[30] ? SEG_MAX : root_ff[29:0];
      total_sum = {1'b0, total_ff} + 49'(seg_w);
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_XM: begin
            mul_a = 32'(ang_ff);
            mul_b = 32'(RAD_PER_HALF_SEC_Q40);
         end
         ST_X2M: begin
            mul_a = 32'(prod_ff[40:10]);
            mul_b = 32'(prod_ff[40:10]);
         end
         ST_HM, ST_HL: begin
            mul_a = x2_ff;
            mul_b = 32'(t_ff);
         end
         ST_HR: begin
            mul_a = prod_ff[61:30];
            mul_b = horner_recip(h_idx_ff);
         end
         ST_HQ: begin
            mul_a = 32'(q0_w);
            mul_b = 32'(horner_div(h_idx_ff));
         end
         ST_DY: begin
            mul_a = 32'(dlat_ff);
            mul_b = 32'(scale_ff);
         end
         ST_DV: begin
            mul_a = 32'(dlon_ff);
            mul_b = 32'(scale_ff);
         end
         ST_DL: begin
            mul_a = 32'(prod_ff[25:8]);
            mul_b = 32'(cos_ff);
         end
         ST_DH: begin
            mul_a = 32'(vh_ff);
            mul_b = 32'(cos_ff);
         end
         ST_SAT: begin
            mul_a = 32'(dx_ff[29:0]);
            mul_b = 32'(dx_ff[29:0]);
         end
         ST_SQ2: begin
            mul_a = 32'(dy_ff[29:0]);
            mul_b = 32'(dy_ff[29:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_lat_in   = cur_lat_ff;
      cur_lon_in   = cur_lon_ff;
      start_in     = start_ff;
      prev_lat_in  = prev_lat_ff;
      prev_lon_in  = prev_lon_ff;
      have_prev_in = have_prev_ff;
      scale_in     = csr_wr_en ? csr_wr_data : scale_ff;
      ang_in       = ang_ff;
      dlat_in      = dlat_ff;
      dlon_in      = dlon_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      q0_in        = q0_ff;
      h_idx_in     = h_idx_ff;
      c_in         = c_ff;
      cos_in       = cos_ff;
      vh_in        = vh_ff;
      acc_in       = acc_ff;
      dx16_in      = dx16_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      seg_in       = seg_ff;
      total_in     = total_ff;
      segv_in      = segv_ff;
      load_rsp     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_lat_in = req_lat_arcsec;
               cur_lon_in = req_lon_arcsec;
               start_in   = req_path_start;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            ang_in       = lat_sum[20] ? (21'd0 - lat_sum) : lat_sum;
            dlat_in      = 20'(lat_diff[20] ? (21'd0 - lat_diff) : lat_diff);
            dlon_in      = 21'(lon_diff[21] ? (22'd0 - lon_diff) : lon_diff);
            prev_lat_in  = cur_lat_ff;
            prev_lon_in  = cur_lon_ff;
            have_prev_in = 1'b1;
            if (start_ff || !have_prev_ff) begin
               total_in = '0;
               seg_in   = '0;
               segv_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            // mean latitude never passes half a turn, so one fold lands in a quarter turn
            if (ang_ff > QUARTER_TURN_HALF_SEC) begin
               ang_in = HALF_TURN_HALF_SEC - ang_ff;
            end
            state_in = ST_XM;
         end
         ST_XM: begin
            state_in = ST_X2M;
         end
         ST_X2M: begin
            state_in = ST_X2R;
         end
         ST_X2R: begin
            x2_in    = prod_ff[61:30];
            t_in     = Q30_ONE;
            h_idx_in = '0;
            state_in = ST_HM;
         end
         ST_HM: begin
            state_in = ST_HR;
         end
         ST_HR: begin
            p_in     = prod_ff[61:30];
            state_in = ST_HQ;
         end
         ST_HQ: begin
            q0_in    = q0_w;
            state_in = ST_HC;
         end
         ST_HC: begin
            // reciprocal quotient may be one short
            t_in = Q30_ONE - 31'(q0_ff) - 31'(hc_corr);
            if (h_idx_ff == HORNER_LAST) begin
               state_in = ST_HL;
            end else begin
               h_idx_in = h_idx_ff + 3'd1;
               state_in = ST_HM;
            end
         end
         ST_HL: begin
            state_in = ST_HU;
         end
         ST_HU: begin
            c_in     = (u_w >= Q30_ONE) ? '0 : (Q30_ONE - u_w);
            state_in = ST_COS;
         end
         ST_COS: begin
            cos_in   = COS_W'(cos_sum >> (30 - COS_FRAC_BITS));
            state_in = ST_DY;
         end
         ST_DY: begin
            state_in = ST_DV;
         end
         ST_DV: begin
            dy_in    = DXQ_W'(rnd_sum >> (16 - DIST_FRAC_BITS));
            state_in = ST_DL;
         end
         ST_DL: begin
            vh_in    = prod_ff[43:26];
            state_in = ST_DH;
         end
         ST_DH: begin
            acc_in   = prod_ff[ACC_W-1:0];
            state_in = ST_DS;
         end
         ST_DS: begin
            dx16_in  = DX16_W'(acc_sum >> (COS_FRAC_BITS - 8));
            state_in = ST_DR;
         end
         ST_DR: begin
            dx_in    = DXQ_W'(rnd_sum >> (16 - DIST_FRAC_BITS));
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if ((dx_ff > DXQ_W'(SEG_MAX)) || (dy_ff > DXQ_W'(SEG_MAX))) begin
               root_in  = 31'(SEG_MAX);
               state_in = ST_TOT;
            end else begin
               state_in = ST_SQ2;
            end
         end
         ST_SQ2: begin
            sq_in    = prod_ff[61:0];
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            sq_in    = sq_ff + prod_ff[61:0];
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = 5'd30;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit per step, two radicand bits brought down
            if (rem_sh >= trial) begin
               rem_in  = 32'(rem_sh - trial);
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rem_in  = rem_sh[31:0];
               root_in = {root_ff[29:0], 1'b0};
            end
            sq_in = {sq_ff[59:0], 2'b00};
            if (cnt_ff == 5'd0) begin
               state_in = ST_TOT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_TOT: begin
            seg_in   = seg_w;
            total_in = total_sum[48] ? TOTAL_MAX : total_sum[47:0];
            segv_in  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word register
   always_comb begin
      rsp_seg_in   = rsp_seg_ff;
      rsp_total_in = rsp_total_ff;
      rsp_segv_in  = rsp_segv_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_seg_in   = seg_ff;
         rsp_total_in = total_ff;
         rsp_segv_in  = segv_ff;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         total_ff     <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
         total_ff     <= total_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_lat_ff   <= cur_lat_in;
      cur_lon_ff   <= cur_lon_in;
      start_ff     <= start_in;
      ang_ff       <= ang_in;
      dlat_ff      <= dlat_in;
      dlon_ff      <= dlon_in;
      prod_ff      <= prod_in;
      x2_ff        <= x2_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      q0_ff        <= q0_in;
      h_idx_ff     <= h_idx_in;
      c_ff         <= c_in;
      cos_ff       <= cos_in;
      vh_ff        <= vh_in;
      acc_ff       <= acc_in;
      dx16_ff      <= dx16_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      seg_ff       <= seg_in;
      segv_ff      <= segv_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_total_ff <= rsp_total_in;
      rsp_segv_ff  <= rsp_segv_in;
   end

endmodule

>>> tb/waypoint_path_distance_checker.sv
// checker for the waypoint distance block: predicts every result word and compares it
`timescale 1ns / 100ps

module waypoint_path_distance_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  wpd_pkg::lat_type   req_lat_arcsec,
   input  wpd_pkg::lon_type   req_lon_arcsec,
   input  logic               req_path_start,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  wpd_pkg::seg_type   rsp_segment_dist,
   input  wpd_pkg::total_type rsp_total_dist,
   input  logic               rsp_segment_valid,
   input  logic               csr_wr_en,
   input  wpd_pkg::scale_type csr_wr_data,
   output int                 fail_count,
   output int                 pending
);
   import wpd_pkg::*;

   localparam int DIST_FRAC_BITS = 4;
   localparam int COS_FRAC_BITS  = 16;

   localparam longint unsigned ONE_Q30      = 64'd1 << 30;
   localparam longint unsigned FULL_TURN    = 64'd2592000;
   localparam longint unsigned HALF_TURN    = 64'd1296000;
   localparam longint unsigned QUARTER_TURN = 64'd648000;
   localparam longint unsigned RAD_Q40      = 64'd2665291;
   localparam longint unsigned LEG_MAX      = (64'd1 << 30) - 64'd1;
   localparam longint unsigned RUN_MAX      = (64'd1 << 48) - 64'd1;

   // divisors of the cosine series, innermost term in the top slot
   localparam logic [4:0][7:0] TERM_DIV = {8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

   typedef struct packed {
      seg_type   seg;
      total_type total;
      logic      measured;
   } leg_word_type;

   leg_word_type    predicted_legs[$];
   scale_type       scale_q16 = SCALE_RESET;
   longint          last_lat = 0;
   longint          last_lon = 0;
   bit              have_last = 1'b0;
   longint unsigned run_total = 0;
   int              failures = 0;

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // |cos| of an angle in half arc-seconds, q16
   function automatic longint unsigned abs_cos_q16(input longint unsigned ang);
      longint unsigned a, x, x2, t, u, c;
      a = ang % FULL_TURN;
      if (a > HALF_TURN) a = FULL_TURN - a;
      if (a > QUARTER_TURN) a = HALF_TURN - a;
      x  = (a * RAD_Q40) >> 10;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 4; i >= 0; i--)
         t = ONE_Q30 - ((x2 * t) >> 30) / longint'(TERM_DIV[i]);
      u = ((x2 * t) >> 30) / 64'd2;
      c = (u >= ONE_Q30) ? 64'd0 : ONE_Q30 - u;
      return (c + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned rest, root, bit_w;
      rest  = v;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (rest >= root + bit_w) begin
            rest -= root + bit_w;
            root = (root >> 1) + bit_w;
         end else begin
            root >>= 1;
         end
         bit_w >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned round_dist(input longint unsigned v16);
      return (v16 + (64'd1 << (15 - DIST_FRAC_BITS))) >> (16 - DIST_FRAC_BITS);
   endfunction

   function automatic leg_word_type measure_leg(input lat_type lat_in, input lon_type lon_in,
                                                input logic start);
      longint          lat, lon;
      longint unsigned cosq, dx, dy, seg;
      leg_word_type    w;
      lat = longint'(lat_in);
      lon = longint'(lon_in);
      seg = 0;
      w.measured = 1'b0;
      if (start || !have_last) begin
         run_total = 0;
      end else begin
         cosq = abs_cos_q16(mag(lat + last_lat));
         dy   = round_dist(mag(lat - last_lat) * scale_q16);
         dx   = round_dist((((mag(lon - last_lon) * scale_q16) >> 8) * cosq)
                           >> (COS_FRAC_BITS - 8));
         if (dx > LEG_MAX || dy > LEG_MAX) begin
            seg = LEG_MAX;
         end else begin
            seg = floor_root(dx * dx + dy * dy);
            if (seg > LEG_MAX) seg = LEG_MAX;
         end
         run_total += seg;
         if (run_total > RUN_MAX) run_total = RUN_MAX;
         w.measured = 1'b1;
      end
      last_lat  = lat;
      last_lon  = lon;
      have_last = 1'b1;
      w.seg     = seg[29:0];
      w.total   = run_total[47:0];
      return w;
   endfunction

   function automatic void report_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
      failures++;
      if (failures <= 10)
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : watch
      leg_word_type want;
      if (reset) begin
         predicted_legs.delete();
         scale_q16 = SCALE_RESET;
         last_lat  = 0;
         last_lon  = 0;
         have_last = 1'b0;
         run_total = 0;
      end else begin
         if (csr_wr_en) scale_q16 = csr_wr_data;
         if (req_valid && !req_stall)
            predicted_legs.push_back(measure_leg(req_lat_arcsec, req_lon_arcsec,
                                                 req_path_start));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_legs.size() == 0) begin
               report_field("unexpected word, segment_dist", 64'd0,
                            64'(rsp_segment_dist));
            end else begin
               want = predicted_legs.pop_front();
               if (rsp_segment_dist !== want.seg)
                  report_field("segment_dist", 64'(want.seg), 64'(rsp_segment_dist));
               if (rsp_total_dist !== want.total)
                  report_field("total_dist", 64'(want.total), 64'(rsp_total_dist));
               if (rsp_segment_valid !== want.measured)
                  report_field("segment_valid", 64'(want.measured),
                               64'(rsp_segment_valid));
            end
         end
      end
      pending    <= predicted_legs.size();
      fail_count <= failures;
   end

endmodule

>>> tb/waypoint_path_distance_tb.sv
// top of the waypoint distance testbench: clock, reset, waypoint stimulus and verdict
`timescale 1ns / 100ps

module waypoint_path_distance_tb;
   import wpd_pkg::*;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   lat_type   req_lat_arcsec = '0;
   lon_type   req_lon_arcsec = '0;
   logic      req_path_start = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   seg_type   rsp_segment_dist;
   total_type rsp_total_dist;
   logic      rsp_segment_valid;
   logic      csr_wr_en = 1'b0;
   scale_type csr_wr_data = '0;

   int fail_count;
   int pending_words;
   int idle_odds = 4;
   bit calm = 1'b0;
   int stall_left = 0;

   waypoint_path_distance dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_lat_arcsec    (req_lat_arcsec),
      .req_lon_arcsec    (req_lon_arcsec),
      .req_path_start    (req_path_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_segment_dist  (rsp_segment_dist),
      .rsp_total_dist    (rsp_total_dist),
      .rsp_segment_valid (rsp_segment_valid),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   waypoint_path_distance_checker leg_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_lat_arcsec    (req_lat_arcsec),
      .req_lon_arcsec    (req_lon_arcsec),
      .req_path_start    (req_path_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_segment_dist  (rsp_segment_dist),
      .rsp_total_dist    (rsp_total_dist),
      .rsp_segment_valid (rsp_segment_valid),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .pending           (pending_words)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side holds off in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 6);
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end
   end

   task automatic send_waypoint(input int lat, input int lon, input bit start);
      if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_lat_arcsec <= lat[19:0];
      req_lon_arcsec <= lon[20:0];
      req_path_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_scale(input scale_type value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int clamp(input int v, input int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // uniform latitude, with a fair share close to the poles
   function automatic int any_lat();
      int v;
      if ($urandom_range(0, 3) == 0) begin
         v = 324000 - int'($urandom_range(0, 3000));
         if ($urandom_range(0, 1) == 1) v = -v;
      end else begin
         v = int'($urandom_range(0, 648000)) - 324000;
      end
      return v;
   endfunction

   function automatic int any_lon();
      return int'($urandom_range(0, 1296000)) - 648000;
   endfunction

   // mostly well-formed paths with random walks, some raw noise words
   task automatic random_paths(input int n_words);
      int sent, steps, lat, lon;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(0, 9) == 0) begin
            send_waypoint($urandom, $urandom, 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            steps = $urandom_range(2, 24);
            lat   = any_lat();
            lon   = any_lon();
            send_waypoint(lat, lon, $urandom_range(0, 7) != 0);
            sent++;
            repeat (steps) begin
               if ($urandom_range(0, 5) == 0) begin
                  lat = any_lat();
                  lon = any_lon();
               end else begin
                  lat = clamp(lat + int'($urandom_range(0, 4000)) - 2000, 324000);
                  lon = clamp(lon + int'($urandom_range(0, 4000)) - 2000, 648000);
               end
               send_waypoint(lat, lon, 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first word after reset without the start flag, then a zero leg
      send_waypoint(1000, 2000, 1'b0);
      send_waypoint(1000, 2000, 1'b0);
      send_waypoint(324000, 648000, 1'b0);
      send_waypoint(-324000, -648000, 1'b0);
      // pure longitude step at the pole, cosine near zero
      send_waypoint(-324000, 648000, 1'b0);
      send_waypoint(0, 0, 1'b1);
      send_waypoint(0, 648000, 1'b0);
      // across the antimeridian, no wrap
      send_waypoint(0, -648000, 1'b0);
      // out-of-range bit patterns, mean latitude beyond a quarter turn
      send_waypoint(-524288, -1048576, 1'b0);
      send_waypoint(524287, 1048575, 1'b0);
      send_waypoint(524287, 0, 1'b0);
      send_waypoint(-1, -1, 1'b1);
      send_waypoint(0, 0, 1'b0);
      send_waypoint(0, 1, 1'b0);
      send_waypoint(1, 1, 1'b0);

      // largest scale drives the legs into saturation
      write_scale('1);
      send_waypoint(-524288, -1048576, 1'b1);
      send_waypoint(524287, 1048575, 1'b0);
      send_waypoint(524287, -1048576, 1'b0);
      send_waypoint(-324000, 0, 1'b0);
      send_waypoint(-323999, 0, 1'b0);

      write_scale('0);
      send_waypoint(100, 100, 1'b1);
      send_waypoint(-5000, 7000, 1'b0);

      write_scale(scale_type'(1));
      send_waypoint(0, 0, 1'b1);
      send_waypoint(300000, 600000, 1'b0);

      idle_odds = 3;
      write_scale(SCALE_RESET);
      random_paths(260);

      idle_odds = 0;
      write_scale(scale_type'($urandom));
      random_paths(250);

      idle_odds = 6;
      write_scale('1);
      random_paths(250);

      idle_odds = 2;
      write_scale(scale_type'($urandom_range(1, 4096)));
      random_paths(250);

      idle_odds = 4;
      write_scale(scale_type'($urandom_range(1500000, 2600000)));
      random_paths(250);

      calm = 1'b1;
      write_scale(SCALE_RESET);
      random_paths(250);

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
